[src/jbl_pkg.sv]
// shared types, handshake codes and defaults for the json byte lexer
`default_nettype none

package jbl_pkg;

    // default width of the byte position counter
    localparam int POS_BITS_DEFAULT = 32;

    // one source byte or an end-of-input mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    // one token
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] value_start;
        logic [31:0] value_length;
        logic        last_of_run;
    } out_item_t;

    // outcome of one lex step
    localparam logic [1:0] RES_DONE   = 2'd0;
    localparam logic [1:0] RES_AGAIN  = 2'd1;
    localparam logic [1:0] RES_REPLAY = 2'd2;

    // byte source for a lex step
    localparam logic [1:0] SRC_LIVE  = 2'd0;
    localparam logic [1:0] SRC_LATCH = 2'd1;
    localparam logic [1:0] SRC_HELD  = 2'd2;

    // token routing between pending slot and output register
    localparam logic [1:0] TOK_NONE     = 2'd0;
    localparam logic [1:0] TOK_OUT_NEW  = 2'd1;
    localparam logic [1:0] TOK_PEND_NEW = 2'd2;
    localparam logic [1:0] TOK_FLUSH    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       step;
        logic [1:0] src;
        logic       held_idx;
        logic       load_in;
        logic [1:0] tok_op;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] result;
        logic       emit;
        logic       pend_valid;
        logic       out_free;
        logic       replay_last;
    } dp_status_t;

endpackage

`default_nettype wire

[src/json_byte_lexer.sv]
// Byte-serial JSON lexer. One byte (or an end-of-input mark) is taken per transfer on the
// s_ channel and the tokens it completes leave on the m_ channel, the last one of each
// input item flagged by last_of_run. A single lex unit runs one lex step per clock: the
// item's own byte, each re-lex of that byte after a keyword mismatch, a lone minus or a
// number end, and each held tail byte ('.', 'e' or exponent sign with no digit after it)
// replayed ahead of it. An item runs its lex steps, then a flush of the pending token
// when its last step emits a token and an earlier step already emitted one. End of
// input runs the same way: one step per unfinished token, the held tail bytes, then the
// end token. Every step waits for the single output register to be free, so a stall on
// the m_ side holds the s_ side; with m_ready high the next transfer is accepted on the
// cycle after the item's last step or flush.
`default_nettype none

module json_byte_lexer #(
    parameter int POSITION_BITS = jbl_pkg::POS_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire jbl_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output jbl_pkg::out_item_t      m_data
);
    import jbl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // step sequencing
    jbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // lexer state and token registers
    jbl_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[src/jbl_ctrl.sv]
// sequencer for the json byte lexer: input acceptance, re-lex, tail replay, token flush
`default_nettype none

module jbl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire jbl_pkg::dp_status_t status,
    output jbl_pkg::dp_cmd_t         cmd
);
    import jbl_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAIN   = 2'd1;
    localparam logic [1:0] ST_REPLAY = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       idx_reg, idx_next;
    logic [1:0] main_tok;
    logic [1:0] main_state;

    // routing and follow-up state after a step on the item's own byte
    always_comb begin
        main_tok   = TOK_NONE;
        main_state = ST_MAIN;
        if (status.result == RES_DONE) begin
            main_state = ST_IDLE;
            if (status.emit && status.pend_valid) begin
                main_tok   = TOK_PEND_NEW;
                main_state = ST_FLUSH;
            end else if (status.emit) begin
                main_tok = TOK_OUT_NEW;
            end else if (status.pend_valid) begin
                main_tok = TOK_FLUSH;
            end
        end else if (status.result == RES_REPLAY) begin
            main_tok   = status.emit ? TOK_PEND_NEW : TOK_NONE;
            main_state = ST_REPLAY;
        end else begin
            main_tok   = status.emit ? TOK_PEND_NEW : TOK_NONE;
            main_state = ST_MAIN;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && status.out_free;

    // state machine
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.step     = 1'b0;
        cmd.src      = SRC_LATCH;
        cmd.held_idx = idx_reg;
        cmd.load_in  = 1'b0;
        cmd.tok_op   = TOK_NONE;
        case (state_reg)
            ST_IDLE: begin
                cmd.src = SRC_LIVE;
                if (s_valid && s_ready) begin
                    cmd.step    = 1'b1;
                    cmd.load_in = 1'b1;
                    cmd.tok_op  = main_tok;
                    state_next  = main_state;
                    idx_next    = 1'b0;
                end
            end
            ST_MAIN: begin
                if (status.out_free) begin
                    cmd.step   = 1'b1;
                    cmd.tok_op = main_tok;
                    state_next = main_state;
                    idx_next   = 1'b0;
                end
            end
            ST_REPLAY: begin
                cmd.src = SRC_HELD;
                if (status.out_free) begin
                    cmd.step   = 1'b1;
                    cmd.tok_op = status.emit ? TOK_PEND_NEW : TOK_NONE;
                    if (status.result != RES_AGAIN) begin
                        if (status.replay_last) begin
                            state_next = ST_MAIN;
                            idx_next   = 1'b0;
                        end else begin
                            idx_next = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.tok_op = TOK_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    // a finished item leaves no token waiting in the pending slot
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.pend_valid)
        else $error("pending token left over while idle");

    // a dropped number tail is always replayed next
    a_replay_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && (cmd.src != SRC_HELD) && (status.result == RES_REPLAY))
        |=> (state_reg == ST_REPLAY))
        else $error("tail replay not started");

    // the flush state always has a token to send
    a_flush_has_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> status.pend_valid)
        else $error("flush with empty pending slot");
`endif

endmodule

`default_nettype wire

[src/jbl_datapath.sv]
// lexer state, one-byte lex step, replay bytes and token output registers
`default_nettype none

module jbl_datapath #(
    parameter int POSITION_BITS = jbl_pkg::POS_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire jbl_pkg::in_item_t   s_data,
    input  wire jbl_pkg::dp_cmd_t    cmd,
    output jbl_pkg::dp_status_t      status,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output jbl_pkg::out_item_t       m_data
);
    import jbl_pkg::*;

    localparam int ExtBits = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    // scan modes
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_STR      = 4'd1;
    localparam logic [3:0] M_KW_TRUE  = 4'd2;
    localparam logic [3:0] M_KW_FALSE = 4'd3;
    localparam logic [3:0] M_KW_NULL  = 4'd4;
    localparam logic [3:0] M_MINUS    = 4'd5;
    localparam logic [3:0] M_ZERO     = 4'd6;
    localparam logic [3:0] M_DIGITS   = 4'd7;
    localparam logic [3:0] M_DOT      = 4'd8;
    localparam logic [3:0] M_FRAC     = 4'd9;
    localparam logic [3:0] M_E        = 4'd10;
    localparam logic [3:0] M_ESIGN    = 4'd11;
    localparam logic [3:0] M_EXP      = 4'd12;

    // token kinds
    localparam logic [3:0] K_NUMBER  = 4'd0;
    localparam logic [3:0] K_STRING  = 4'd1;
    localparam logic [3:0] K_TRUE    = 4'd2;
    localparam logic [3:0] K_FALSE   = 4'd3;
    localparam logic [3:0] K_NULL    = 4'd4;
    localparam logic [3:0] K_COLON   = 4'd5;
    localparam logic [3:0] K_COMMA   = 4'd6;
    localparam logic [3:0] K_LBRACE  = 4'd7;
    localparam logic [3:0] K_RBRACE  = 4'd8;
    localparam logic [3:0] K_LBRACK  = 4'd9;
    localparam logic [3:0] K_RBRACK  = 4'd10;
    localparam logic [3:0] K_ERROR   = 4'd11;
    localparam logic [3:0] K_END     = 4'd12;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LE     = "e";
    localparam logic [7:0] CH_UE     = "E";
    localparam logic [7:0] CH_LF_    = "f";
    localparam logic [7:0] CH_LL     = "l";
    localparam logic [7:0] CH_LN     = "n";
    localparam logic [7:0] CH_LR     = "r";
    localparam logic [7:0] CH_LS     = "s";
    localparam logic [7:0] CH_LT     = "t";
    localparam logic [7:0] CH_LU     = "u";

    // expected keyword byte after the first letter
    function automatic logic [7:0] kw_char(input logic [3:0] mode, input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        case (mode)
            M_KW_TRUE: begin
                case (idx)
                    3'd0:    c = CH_LR;
                    3'd1:    c = CH_LU;
                    3'd2:    c = CH_LE;
                    default: c = CH_NUL;
                endcase
            end
            M_KW_FALSE: begin
                case (idx)
                    3'd0:    c = CH_LA;
                    3'd1:    c = CH_LL;
                    3'd2:    c = CH_LS;
                    3'd3:    c = CH_LE;
                    default: c = CH_NUL;
                endcase
            end
            M_KW_NULL: begin
                case (idx)
                    3'd0:    c = CH_LU;
                    3'd1:    c = CH_LL;
                    3'd2:    c = CH_LL;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // keyword bytes left after the first letter
    function automatic logic [2:0] kw_len(input logic [3:0] mode);
        logic [2:0] n;
        case (mode)
            M_KW_FALSE: n = 3'd4;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] kw_kind(input logic [3:0] mode);
        logic [3:0] k;
        case (mode)
            M_KW_TRUE:  k = K_TRUE;
            M_KW_FALSE: k = K_FALSE;
            default:    k = K_NULL;
        endcase
        return k;
    endfunction

    // lexer state
    logic [3:0]               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tb_reg, tb_next;
    logic [2:0]               kp_reg, kp_next;
    logic                     esc_reg, esc_next;
    logic [1:0]               rc_reg, rc_next;
    logic [1:0]               tail_cnt_reg, tail_cnt_next;
    logic [7:0]               held_reg [2];
    in_item_t                 in_item_reg, in_item_next;

    // output side
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic      pend_valid_reg, pend_valid_next;
    out_item_t pend_reg, pend_next;

    // lex step signals
    logic [7:0]               sel_byte;
    logic                     sel_fin;
    logic [POSITION_BITS-1:0] replay_pos, lex_pos;
    logic [POSITION_BITS-1:0] num_len, tail_len;
    logic                     is_dig;
    logic                     kw_hit;
    logic [2:0]               kp_inc;
    logic [3:0]               lx_mode;
    logic [POSITION_BITS-1:0] lx_pos, lx_tb;
    logic [2:0]               lx_kp;
    logic                     lx_esc;
    logic [1:0]               lx_rc;
    logic                     lx_wr0, lx_wr1;
    logic                     lx_emit;
    logic [3:0]               lx_kind;
    logic [POSITION_BITS-1:0] lx_start, lx_len;
    logic [1:0]               lx_res;
    logic [ExtBits-1:0]       start_ext, len_ext;
    out_item_t                new_tok;

    // byte and position feeding the lex step
    always_comb begin
        case (cmd.src)
            SRC_LIVE: begin
                sel_byte = s_data.in_byte;
                sel_fin  = s_data.end_of_input;
            end
            SRC_HELD: begin
                sel_byte = held_reg[cmd.held_idx];
                sel_fin  = 1'b0;
            end
            default: begin
                sel_byte = in_item_reg.in_byte;
                sel_fin  = in_item_reg.end_of_input;
            end
        endcase
    end

    assign replay_pos = pos_reg - POSITION_BITS'(tail_cnt_reg)
                        + POSITION_BITS'(cmd.held_idx);
    assign lex_pos    = (cmd.src == SRC_HELD) ? replay_pos : pos_reg;
    assign num_len    = lex_pos - tb_reg;
    assign tail_len   = lex_pos - POSITION_BITS'(rc_reg) - tb_reg;
    assign is_dig     = sel_byte inside {[CH_0:CH_9]};
    assign kw_hit     = (kp_reg < kw_len(mode_reg)) && (sel_byte == kw_char(mode_reg, kp_reg));
    assign kp_inc     = kp_reg + 3'd1;

    // one lex step: one byte, or one end-of-stream step
    always_comb begin
        lx_mode  = mode_reg;
        lx_pos   = pos_reg;
        lx_tb    = tb_reg;
        lx_kp    = kp_reg;
        lx_esc   = esc_reg;
        lx_rc    = rc_reg;
        lx_wr0   = 1'b0;
        lx_wr1   = 1'b0;
        lx_emit  = 1'b0;
        lx_kind  = K_ERROR;
        lx_start = '0;
        lx_len   = '0;
        lx_res   = RES_DONE;
        if (sel_fin) begin
            case (mode_reg)
                M_IDLE: begin
                    lx_emit = 1'b1;
                    lx_kind = K_END;
                    lx_pos  = '0;
                    lx_tb   = '0;
                    lx_kp   = '0;
                    lx_esc  = 1'b0;
                    lx_rc   = '0;
                end
                M_ZERO, M_DIGITS, M_FRAC, M_EXP: begin
                    lx_emit  = 1'b1;
                    lx_kind  = K_NUMBER;
                    lx_start = tb_reg;
                    lx_len   = num_len;
                    lx_mode  = M_IDLE;
                    lx_res   = RES_AGAIN;
                end
                M_DOT, M_E, M_ESIGN: begin
                    lx_emit  = 1'b1;
                    lx_kind  = K_NUMBER;
                    lx_start = tb_reg;
                    lx_len   = tail_len;
                    lx_mode  = M_IDLE;
                    lx_rc    = '0;
                    lx_res   = RES_REPLAY;
                end
                default: begin
                    lx_emit = 1'b1;
                    lx_mode = M_IDLE;
                    lx_res  = RES_AGAIN;
                end
            endcase
        end else begin
            case (mode_reg)
                M_IDLE: begin
                    case (sel_byte)
                        CH_SP, CH_TAB, CH_LF, CH_CR: begin
                        end
                        CH_COLON:  begin lx_emit = 1'b1; lx_kind = K_COLON;  end
                        CH_COMMA:  begin lx_emit = 1'b1; lx_kind = K_COMMA;  end
                        CH_LBRACE: begin lx_emit = 1'b1; lx_kind = K_LBRACE; end
                        CH_RBRACE: begin lx_emit = 1'b1; lx_kind = K_RBRACE; end
                        CH_LBRACK: begin lx_emit = 1'b1; lx_kind = K_LBRACK; end
                        CH_RBRACK: begin lx_emit = 1'b1; lx_kind = K_RBRACK; end
                        CH_LT:     begin lx_mode = M_KW_TRUE;  lx_kp = '0; end
                        CH_LF_:    begin lx_mode = M_KW_FALSE; lx_kp = '0; end
                        CH_LN:     begin lx_mode = M_KW_NULL;  lx_kp = '0; end
                        CH_QUOTE: begin
                            lx_mode = M_STR;
                            lx_esc  = 1'b0;
                            lx_tb   = lex_pos + POSITION_BITS'(1);
                        end
                        CH_MINUS: begin lx_mode = M_MINUS; lx_tb = lex_pos; end
                        CH_0:     begin lx_mode = M_ZERO;  lx_tb = lex_pos; end
                        default: begin
                            if (is_dig) begin
                                lx_mode = M_DIGITS;
                                lx_tb   = lex_pos;
                            end else begin
                                lx_emit = 1'b1;
                            end
                        end
                    endcase
                end
                M_STR: begin
                    // a backslash escapes exactly the next byte
                    if (esc_reg) begin
                        lx_esc = 1'b0;
                    end else if (sel_byte == CH_BSLASH) begin
                        lx_esc = 1'b1;
                    end else if (sel_byte == CH_QUOTE) begin
                        lx_emit  = 1'b1;
                        lx_kind  = K_STRING;
                        lx_start = tb_reg;
                        lx_len   = num_len;
                        lx_mode  = M_IDLE;
                    end
                end
                M_KW_TRUE, M_KW_FALSE, M_KW_NULL: begin
                    if (kw_hit) begin
                        lx_kp = kp_inc;
                        if (kp_inc >= kw_len(mode_reg)) begin
                            lx_emit = 1'b1;
                            lx_kind = kw_kind(mode_reg);
                            lx_mode = M_IDLE;
                            lx_kp   = '0;
                        end
                    end else begin
                        lx_emit = 1'b1;
                        lx_mode = M_IDLE;
                        lx_kp   = '0;
                        lx_res  = RES_AGAIN;
                    end
                end
                M_MINUS: begin
                    if (sel_byte == CH_0) begin
                        lx_mode = M_ZERO;
                    end else if (is_dig) begin
                        lx_mode = M_DIGITS;
                    end else begin
                        lx_emit = 1'b1;
                        lx_mode = M_IDLE;
                        lx_res  = RES_AGAIN;
                    end
                end
                M_ZERO, M_DIGITS, M_FRAC: begin
                    if (is_dig && (mode_reg != M_ZERO)) begin
                    end else if ((sel_byte == CH_DOT) && (mode_reg != M_FRAC)) begin
                        lx_mode = M_DOT;
                        lx_wr0  = 1'b1;
                        lx_rc   = 2'd1;
                    end else if (sel_byte inside {CH_LE, CH_UE}) begin
                        lx_mode = M_E;
                        lx_wr0  = 1'b1;
                        lx_rc   = 2'd1;
                    end else begin
                        lx_emit  = 1'b1;
                        lx_kind  = K_NUMBER;
                        lx_start = tb_reg;
                        lx_len   = num_len;
                        lx_mode  = M_IDLE;
                        lx_res   = RES_AGAIN;
                    end
                end
                M_DOT, M_E, M_ESIGN: begin
                    if (is_dig) begin
                        lx_mode = (mode_reg == M_DOT) ? M_FRAC : M_EXP;
                        lx_rc   = '0;
                    end else if ((mode_reg == M_E) && (sel_byte inside {CH_PLUS, CH_MINUS})) begin
                        lx_mode = M_ESIGN;
                        lx_wr1  = 1'b1;
                        lx_rc   = 2'd2;
                    end else begin
                        // drop the unconfirmed tail and lex it again
                        lx_emit  = 1'b1;
                        lx_kind  = K_NUMBER;
                        lx_start = tb_reg;
                        lx_len   = tail_len;
                        lx_mode  = M_IDLE;
                        lx_rc    = '0;
                        lx_res   = RES_REPLAY;
                    end
                end
                M_EXP: begin
                    if (!is_dig) begin
                        lx_emit  = 1'b1;
                        lx_kind  = K_NUMBER;
                        lx_start = tb_reg;
                        lx_len   = num_len;
                        lx_mode  = M_IDLE;
                        lx_res   = RES_AGAIN;
                    end
                end
                default: begin
                    lx_mode = M_IDLE;
                    lx_res  = RES_AGAIN;
                end
            endcase
            // the item's own byte is consumed
            if ((lx_res == RES_DONE) && (cmd.src != SRC_HELD)) begin
                lx_pos = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    // token built by this step
    assign start_ext = ExtBits'(lx_start);
    assign len_ext   = ExtBits'(lx_len);
    always_comb begin
        new_tok.token_kind   = lx_kind;
        new_tok.value_start  = start_ext[31:0];
        new_tok.value_length = len_ext[31:0];
        new_tok.last_of_run  = 1'b0;
    end

    // state update
    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        tb_next       = tb_reg;
        kp_next       = kp_reg;
        esc_next      = esc_reg;
        rc_next       = rc_reg;
        tail_cnt_next = tail_cnt_reg;
        in_item_next  = cmd.load_in ? s_data : in_item_reg;
        if (cmd.step) begin
            mode_next = lx_mode;
            pos_next  = lx_pos;
            tb_next   = lx_tb;
            kp_next   = lx_kp;
            esc_next  = lx_esc;
            rc_next   = lx_rc;
            if (lx_res == RES_REPLAY) begin
                tail_cnt_next = rc_reg;
            end
        end
    end

    // pending slot and output register
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        case (cmd.tok_op)
            TOK_OUT_NEW: begin
                m_valid_next             = 1'b1;
                m_data_next              = new_tok;
                m_data_next.last_of_run  = 1'b1;
            end
            TOK_PEND_NEW: begin
                if (pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                end
                pend_valid_next = 1'b1;
                pend_next       = new_tok;
            end
            TOK_FLUSH: begin
                if (pend_valid_reg) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = pend_reg;
                    m_data_next.last_of_run = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            pos_reg        <= '0;
            tb_reg         <= '0;
            kp_reg         <= '0;
            esc_reg        <= 1'b0;
            rc_reg         <= '0;
            tail_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            tb_reg         <= tb_next;
            kp_reg         <= kp_next;
            esc_reg        <= esc_next;
            rc_reg         <= rc_next;
            tail_cnt_reg   <= tail_cnt_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        m_data_reg  <= m_data_next;
        pend_reg    <= pend_next;
        if (cmd.step && lx_wr0) begin
            held_reg[0] <= sel_byte;
        end
        if (cmd.step && lx_wr1) begin
            held_reg[1] <= sel_byte;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status.result      = lx_res;
        status.emit        = lx_emit;
        status.pend_valid  = pend_valid_reg;
        status.out_free    = !m_valid_reg || m_ready;
        status.replay_last = (2'({1'b0, cmd.held_idx}) + 2'd1) == tail_cnt_reg;
    end

`ifndef SYNTHESIS
    // the end token always closes its run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.token_kind == K_END)) |-> m_data_reg.last_of_run)
        else $error("end token without last_of_run");

    // position only moves on a lex step
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.step |=> $stable(pos_reg))
        else $error("byte position moved without a lex step");

    // replaying held bytes needs a held count
    a_tail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && (cmd.src == SRC_HELD)) |-> (tail_cnt_reg != 2'd0))
        else $error("replay with no held bytes");
`endif

endmodule

`default_nettype wire
